// ===== hdl/rrd_pkg.sv =====
// rrd_pkg: shared types and constants of the multibulk request deframer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rrd_pkg;

    localparam int EV_W  = 3;
    localparam int IDX_W = 10;
    localparam int ERR_W = 2;
    localparam int ACC_W = 33;

    // event codes
    localparam logic [EV_W-1:0] EV_DATA      = 3'd0;
    localparam logic [EV_W-1:0] EV_PAR_END   = 3'd1;
    localparam logic [EV_W-1:0] EV_PAR_NULL  = 3'd2;
    localparam logic [EV_W-1:0] EV_INLINE    = 3'd3;
    localparam logic [EV_W-1:0] EV_QUIT      = 3'd4;
    localparam logic [EV_W-1:0] EV_PROTO_ERR = 3'd5;

    // protocol error kinds
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_COUNT = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NO_DOLLAR = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_LEN   = 2'd3;

    // characters
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_Q      = 8'h51;
    localparam logic [7:0] CH_U      = 8'h55;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_T      = 8'h54;

    typedef struct packed {
        logic [EV_W-1:0]  event_res;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] param_index;
        logic             command_end;
        logic             command_known;
        logic [ERR_W-1:0] error_kind;
    } rrd_res_t;

endpackage

// ===== hdl/rrd_out_reg.sv =====
// rrd_out_reg: result register of the deframer with valid / stall handshake
// depends on rrd_pkg for the result type
`timescale 1ns / 1ps

module rrd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rrd_pkg::rrd_res_t res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_stall,
    output rrd_pkg::rrd_res_t out_res
);
    import rrd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rrd_res_t res_reg;

    // slot can take a result when empty or when the held one leaves now
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || !out_stall))
        else $error("result register overwritten while held");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall && !load) |=> (valid_reg && res_reg == $past(res_reg)))
        else $error("stalled result lost or changed");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

endmodule

// ===== hdl/rrd_parser.sv =====
// rrd_parser: per-byte parse state and single-pass next-state / result logic
// depends on rrd_pkg; fed from the input register, feeds rrd_out_reg
`timescale 1ns / 1ps

module rrd_parser #(
    parameter int MAX_PARAMS = 1024,
    parameter int LEN_BITS   = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic [7:0]        byte_in,
    input  logic              out_free,
    output logic              take,
    output logic              res_load,
    output rrd_pkg::rrd_res_t res
);
    import rrd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PARAMS + 1);
    localparam logic [ACC_W-1:0] COUNT_MAX = ACC_W'(MAX_PARAMS);
    localparam logic [ACC_W-1:0] LEN_MAX   = (ACC_W'(1) << LEN_BITS) - ACC_W'(1);

    typedef enum logic [3:0] {
        PH_REQ_START,
        PH_REQ_COUNT,
        PH_REQ_INLINE,
        PH_PAR_START,
        PH_PAR_LEN,
        PH_PAR_BAD,
        PH_DATA,
        PH_SKIP1,
        PH_SKIP2,
        PH_COUNT_BAD,
        PH_LEN_BAD
    } phase_t;

    // state of the line being parsed
    typedef struct packed {
        phase_t           phase;
        logic [ACC_W-1:0] accum;
        logic             neg;
        logic             nvalid;
        logic [2:0]       pos;
        logic             mis;
    } line_t;

    function automatic line_t begin_line(phase_t ph);
        line_t r;
        r.phase  = ph;
        r.accum  = '0;
        r.neg    = 1'b0;
        r.nvalid = 1'b0;
        r.pos    = '0;
        r.mis    = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] quit_char(logic [1:0] p);
        logic [7:0] c;
        case (p)
            2'd0:    c = CH_Q;
            2'd1:    c = CH_U;
            2'd2:    c = CH_I;
            default: c = CH_T;
        endcase
        return c;
    endfunction

    function automatic line_t number_step(line_t l, logic [7:0] b, phase_t bad);
        line_t       r;
        logic [36:0] prod;
        logic [3:0]  digit;
        r     = l;
        digit = 4'(b - CH_0);
        prod  = ({4'b0, l.accum} << 3) + ({4'b0, l.accum} << 1) + 37'(digit);
        if (b inside {[CH_0:CH_9]})
        begin
            // saturate at the top of the accumulator
            r.accum  = (|prod[36:ACC_W]) ? '1 : prod[ACC_W-1:0];
            r.nvalid = 1'b1;
        end
        else if ((b == CH_MINUS || b == CH_PLUS) && l.pos == 3'd0)
        begin
            r.neg = (b == CH_MINUS);
        end
        else
        begin
            r.phase = bad;
        end
        r.pos = 3'd1;
        return r;
    endfunction

    function automatic line_t inline_step(line_t l, logic [7:0] b);
        line_t      r;
        logic [7:0] up;
        r  = l;
        up = (b inside {[CH_LA:CH_LZ]}) ? b - 8'd32 : b;
        if (l.pos < 3'd4 && up == quit_char(l.pos[1:0]))
        begin
            r.pos = l.pos + 3'd1;
        end
        else
        begin
            r.mis = 1'b1;
        end
        return r;
    endfunction

    function automatic line_t content_step(line_t l, logic [7:0] b);
        line_t r;
        r = l;
        case (l.phase)
            PH_REQ_START:
            begin
                if (b == CH_STAR)
                begin
                    r.phase = PH_REQ_COUNT;
                end
                else
                begin
                    r.phase = PH_REQ_INLINE;
                    r       = inline_step(r, b);
                end
            end
            PH_REQ_COUNT:  r = number_step(l, b, PH_COUNT_BAD);
            PH_REQ_INLINE: r = inline_step(l, b);
            PH_PAR_START:  r.phase = (b == CH_DOLLAR) ? PH_PAR_LEN : PH_PAR_BAD;
            PH_PAR_LEN:    r = number_step(l, b, PH_LEN_BAD);
            default:       r = l;
        endcase
        return r;
    endfunction

    function automatic rrd_res_t mk_res(logic [EV_W-1:0] ev, logic [7:0] d,
                                        logic [IDX_W-1:0] idx, logic cend,
                                        logic known, logic [ERR_W-1:0] err);
        rrd_res_t r;
        r.event_res     = ev;
        r.data_byte     = d;
        r.param_index   = idx;
        r.command_end   = cend;
        r.command_known = known;
        r.error_kind    = err;
        return r;
    endfunction

    line_t               line_reg, line_next, line_cr;
    logic [CNT_W-1:0]    exp_reg, exp_next;
    logic [CNT_W-1:0]    seen_reg, seen_next, seen_inc;
    logic [LEN_BITS-1:0] left_reg, left_next;
    logic                cr_reg, cr_next;
    logic                first_z_reg, first_z_next;
    logic                closed_reg, closed_next;
    logic                res_hit;
    logic                last_par;
    logic [IDX_W-1:0]    idx_cur;
    rrd_res_t            res_c;

    assign seen_inc = seen_reg + CNT_W'(1);
    assign last_par = (seen_inc == exp_reg);
    assign idx_cur  = IDX_W'(seen_reg);
    // a CR that turned out not to end the line is ordinary content
    assign line_cr  = content_step(line_reg, CH_CR);

    always_comb
    begin
        line_next    = line_reg;
        exp_next     = exp_reg;
        seen_next    = seen_reg;
        left_next    = left_reg;
        cr_next      = cr_reg;
        first_z_next = first_z_reg;
        closed_next  = closed_reg;
        res_hit      = 1'b0;
        res_c        = mk_res(EV_DATA, 8'd0, '0, 1'b0, 1'b0, ERR_NONE);

        if (!closed_reg)
        begin
            case (line_reg.phase)
                PH_DATA:
                begin
                    if (seen_reg == '0 && ACC_W'(left_reg) == line_reg.accum)
                    begin
                        first_z_next = (byte_in == CH_UZ) || (byte_in == CH_LZ);
                    end
                    if (left_reg != '0)
                    begin
                        left_next = left_reg - LEN_BITS'(1);
                    end
                    if (left_next == '0)
                    begin
                        line_next.phase = PH_SKIP1;
                    end
                    res_hit = 1'b1;
                    res_c   = mk_res(EV_DATA, byte_in, idx_cur, 1'b0, 1'b0, ERR_NONE);
                end
                PH_SKIP1:
                begin
                    line_next.phase = PH_SKIP2;
                end
                PH_SKIP2:
                begin
                    seen_next = seen_inc;
                    line_next = begin_line(last_par ? PH_REQ_START : PH_PAR_START);
                    res_hit   = 1'b1;
                    res_c     = mk_res(EV_PAR_END, 8'd0, idx_cur, last_par,
                                       last_par && first_z_reg, ERR_NONE);
                end
                default:
                begin
                    if (cr_reg && byte_in == CH_LF)
                    begin
                        cr_next = 1'b0;
                        // end of line
                        case (line_reg.phase)
                            PH_REQ_START:
                            begin
                                line_next = begin_line(PH_REQ_START);
                            end
                            PH_REQ_INLINE:
                            begin
                                res_hit = 1'b1;
                                if (!line_reg.mis && line_reg.pos == 3'd4)
                                begin
                                    closed_next = 1'b1;
                                    res_c = mk_res(EV_QUIT, 8'd0, '0, 1'b0, 1'b0, ERR_NONE);
                                end
                                else
                                begin
                                    line_next = begin_line(PH_REQ_START);
                                    res_c = mk_res(EV_INLINE, 8'd0, '0, 1'b0, 1'b0,
                                                   ERR_NONE);
                                end
                            end
                            PH_REQ_COUNT:
                            begin
                                if (!line_reg.nvalid
                                    || (line_reg.neg && line_reg.accum != '0)
                                    || line_reg.accum > COUNT_MAX)
                                begin
                                    res_hit     = 1'b1;
                                    closed_next = 1'b1;
                                    res_c = mk_res(EV_PROTO_ERR, 8'd0, '0, 1'b0, 1'b0,
                                                   ERR_BAD_COUNT);
                                end
                                else if (line_reg.accum == '0)
                                begin
                                    line_next = begin_line(PH_REQ_START);
                                end
                                else
                                begin
                                    exp_next     = line_reg.accum[CNT_W-1:0];
                                    seen_next    = '0;
                                    first_z_next = 1'b0;
                                    line_next    = begin_line(PH_PAR_START);
                                end
                            end
                            PH_COUNT_BAD:
                            begin
                                res_hit     = 1'b1;
                                closed_next = 1'b1;
                                res_c = mk_res(EV_PROTO_ERR, 8'd0, '0, 1'b0, 1'b0,
                                               ERR_BAD_COUNT);
                            end
                            PH_PAR_START, PH_PAR_BAD:
                            begin
                                res_hit     = 1'b1;
                                closed_next = 1'b1;
                                res_c = mk_res(EV_PROTO_ERR, 8'd0, idx_cur, 1'b0, 1'b0,
                                               ERR_NO_DOLLAR);
                            end
                            PH_LEN_BAD:
                            begin
                                res_hit     = 1'b1;
                                closed_next = 1'b1;
                                res_c = mk_res(EV_PROTO_ERR, 8'd0, idx_cur, 1'b0, 1'b0,
                                               ERR_BAD_LEN);
                            end
                            PH_PAR_LEN:
                            begin
                                if (line_reg.nvalid && line_reg.neg
                                    && line_reg.accum == ACC_W'(1))
                                begin
                                    // null parameter
                                    seen_next = seen_inc;
                                    line_next = begin_line(last_par ? PH_REQ_START
                                                                    : PH_PAR_START);
                                    res_hit   = 1'b1;
                                    res_c     = mk_res(EV_PAR_NULL, 8'd0, idx_cur, last_par,
                                                       last_par && first_z_reg, ERR_NONE);
                                end
                                else if (!line_reg.nvalid
                                         || (line_reg.neg && line_reg.accum != '0)
                                         || line_reg.accum > LEN_MAX)
                                begin
                                    res_hit     = 1'b1;
                                    closed_next = 1'b1;
                                    res_c = mk_res(EV_PROTO_ERR, 8'd0, idx_cur, 1'b0, 1'b0,
                                                   ERR_BAD_LEN);
                                end
                                else
                                begin
                                    left_next       = line_reg.accum[LEN_BITS-1:0];
                                    line_next.phase = (line_reg.accum == '0) ? PH_SKIP1
                                                                             : PH_DATA;
                                end
                            end
                            default:
                            begin
                                line_next = line_reg;
                            end
                        endcase
                    end
                    else
                    begin
                        if (byte_in == CH_CR)
                        begin
                            cr_next   = 1'b1;
                            line_next = cr_reg ? line_cr : line_reg;
                        end
                        else
                        begin
                            cr_next   = 1'b0;
                            line_next = content_step(cr_reg ? line_cr : line_reg, byte_in);
                        end
                    end
                end
            endcase
        end
    end

    // a byte with no result may pass even while the result slot is held
    assign take     = byte_valid && (out_free || !res_hit);
    assign res_load = take && res_hit;
    assign res      = res_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg    <= begin_line(PH_REQ_START);
            exp_reg     <= '0;
            seen_reg    <= '0;
            left_reg    <= '0;
            cr_reg      <= 1'b0;
            first_z_reg <= 1'b0;
            closed_reg  <= 1'b0;
        end
        else if (take)
        begin
            line_reg    <= line_next;
            exp_reg     <= exp_next;
            seen_reg    <= seen_next;
            left_reg    <= left_next;
            cr_reg      <= cr_next;
            first_z_reg <= first_z_next;
            closed_reg  <= closed_next;
        end
    end

    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("closed connection reopened");

    a_close_on_fatal: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (res.event_res == EV_QUIT || res.event_res == EV_PROTO_ERR))
        |=> closed_reg)
        else $error("quit or protocol error did not close");

    a_silent_when_closed: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |-> !res_load)
        else $error("result produced after close");

    a_seen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (line_reg.phase == PH_DATA || line_reg.phase == PH_SKIP1
         || line_reg.phase == PH_SKIP2 || line_reg.phase == PH_PAR_LEN)
        |-> (seen_reg < exp_reg))
        else $error("parameter index beyond count");

    a_end_on_param: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.command_end)
        |-> (res.event_res == EV_PAR_END || res.event_res == EV_PAR_NULL))
        else $error("command end on wrong event");

endmodule

// ===== hdl/resp_request_deframer_top.sv =====
// path: an accepted byte is held in the input register, passes the parse logic, and its result
// is loaded into the result register, which drives the output
// throughput: one byte per cycle; each byte takes one pass through the parse logic
// between the input register and the result register, bytes with no result never wait
// on a held result, and a byte with a result waits only while the held one is stalled
// reset (rst_n, async) returns the parser to the start of a request line and empties both registers
`timescale 1ns / 1ps

module resp_request_deframer_top #(
    parameter int MAX_PARAMS = 1024,
    parameter int LEN_BITS   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rrd_pkg::EV_W-1:0]       event_res,
    output logic [7:0]                     data_byte,
    output logic [rrd_pkg::IDX_W-1:0]      param_index,
    output logic                           command_end,
    output logic                           command_known,
    output logic [rrd_pkg::ERR_W-1:0]      error_kind
);
    import rrd_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_xfer;
    logic       take;
    logic       res_load;
    logic       free;
    rrd_res_t   res;
    rrd_res_t   out_res;

    assign in_stall = in_valid_reg && !take;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else
        begin
            in_valid_next = in_valid_reg && !take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    rrd_parser #(
        .MAX_PARAMS (MAX_PARAMS),
        .LEN_BITS   (LEN_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_valid_reg),
        .byte_in    (in_byte_reg),
        .out_free   (free),
        .take       (take),
        .res_load   (res_load),
        .res        (res)
    );

    rrd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign event_res     = out_res.event_res;
    assign data_byte     = out_res.data_byte;
    assign param_index   = out_res.param_index;
    assign command_end   = out_res.command_end;
    assign command_known = out_res.command_known;
    assign error_kind    = out_res.error_kind;

endmodule
